// ----- design/rgba_to_yuv420_converter_macros.svh -----
// ----------------------------------------------------------------------------
// RGBA to YUV 4:2:0 converter assertion macros
// Shared concurrent assertion forms used by the converter top module.
// ----------------------------------------------------------------------------
`ifndef RGBA_TO_YUV420_CONVERTER_MACROS_SVH
`define RGBA_TO_YUV420_CONVERTER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define R2Y_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define R2Y_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define R2Y_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define R2Y_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- design/r2y_pkg.sv -----
// ----------------------------------------------------------------------------
// RGBA to YUV 4:2:0 converter package
// Shared widths, register codes, reset values and types.
// ----------------------------------------------------------------------------
package r2y_pkg;

   localparam int MAX_DIM_BITS = 12;
   localparam int DIM_W        = MAX_DIM_BITS + 1;
   localparam int CFG_SIZE_W   = 13;
   localparam int STRIDE_W     = 15;
   localparam int ADDR_W       = 26;
   localparam int PROD_W       = MAX_DIM_BITS + STRIDE_W;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 15;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_WIDTH         = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_HEIGHT        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LUMA_ROW_STRIDE    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_ROW_STRIDE  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_CHROMA_INTERLEAVED = 3'd6;

   localparam logic [CFG_SIZE_W-1:0] RESET_WIDTH  = 13'd1920;
   localparam logic [CFG_SIZE_W-1:0] RESET_HEIGHT = 13'd1080;
   localparam logic [STRIDE_W-1:0]   RESET_STRIDE = 15'd1920;

   typedef struct packed {
      logic [CFG_SIZE_W-1:0] source_width;
      logic [CFG_SIZE_W-1:0] source_height;
      logic [CFG_SIZE_W-1:0] dest_width;
      logic [CFG_SIZE_W-1:0] dest_height;
   } frame_cfg_type;

   typedef struct packed {
      logic [MAX_DIM_BITS-1:0] column;
      logic [MAX_DIM_BITS-1:0] row;
      logic                    in_window;
      logic                    chroma;
      logic                    last;
   } pixel_pos_type;

endpackage

// ----- design/rgba_to_yuv420_converter.sv -----
// ----------------------------------------------------------------------------
// RGBA to YUV 4:2:0 converter
// Converts a raster-order RGB pixel stream into BT.601 luma and chroma
// write transactions with destination byte addresses.
// ----------------------------------------------------------------------------
// Pixels enter on the req_ channel in raster order; alpha is not carried.
// Each pixel inside the copy window (the smaller of source and destination
// sizes) leaves as one transaction on the rsp_ channel with its luma value
// and luma address. Pixels on even rows and columns of the even-sized part
// of the window also carry Cb, Cr and a chroma address, planar or
// interleaved. Pixels outside the window produce no transaction, and
// rsp_frame_done marks the last pixel of the window.
// The datapath has an input register and a result register. One pixel is
// accepted every cycle while results are taken; the color math and the two
// address multipliers are combinational between the registers. When the
// receiver stalls, the result register holds and the input register fills,
// after which req_ready drops until a result is taken. Reset clears both
// pipeline stages and the raster counters and loads the registers with a
// 1920 by 1080 frame, strides of 1920 and planar chroma. The user writes
// registers over the csr_ port only while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
`include "rgba_to_yuv420_converter_macros.svh"

module rgba_to_yuv420_converter
   import r2y_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_red,
   input  logic [7:0]             req_green,
   input  logic [7:0]             req_blue,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_luma,
   output logic [ADDR_W-1:0]      rsp_luma_addr,
   output logic                   rsp_chroma_valid,
   output logic [7:0]             rsp_cb_value,
   output logic [7:0]             rsp_cr_value,
   output logic [ADDR_W-1:0]      rsp_chroma_addr,
   output logic                   rsp_frame_done
);

   frame_cfg_type          frame_cfg_ff;
   logic [STRIDE_W-1:0]    luma_stride_ff;
   logic [STRIDE_W-1:0]    chroma_stride_ff;
   logic                   interleaved_ff;

   pixel_pos_type          pos;
   logic                   req_accept;
   logic                   s2_ready;

   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   pixel_pos_type          s1_pos_ff;
   logic [7:0]             s1_red_ff;
   logic [7:0]             s1_green_ff;
   logic [7:0]             s1_blue_ff;

   logic [7:0]             luma_in;
   logic [7:0]             cb_in;
   logic [7:0]             cr_in;
   logic [PROD_W-1:0]      luma_prod;
   logic [PROD_W-1:0]      chroma_prod;
   logic [MAX_DIM_BITS-1:0] chroma_col_off;
   logic [ADDR_W-1:0]      luma_addr_in;
   logic [ADDR_W-1:0]      chroma_addr_in;

   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [7:0]             out_luma_ff;
   logic [ADDR_W-1:0]      out_luma_addr_ff;
   logic                   out_chroma_valid_ff;
   logic [7:0]             out_cb_ff;
   logic [7:0]             out_cr_ff;
   logic [ADDR_W-1:0]      out_chroma_addr_ff;
   logic                   out_frame_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_cfg_ff.source_width  <= RESET_WIDTH;
         frame_cfg_ff.source_height <= RESET_HEIGHT;
         frame_cfg_ff.dest_width    <= RESET_WIDTH;
         frame_cfg_ff.dest_height   <= RESET_HEIGHT;
         luma_stride_ff             <= RESET_STRIDE;
         chroma_stride_ff           <= RESET_STRIDE;
         interleaved_ff             <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_SOURCE_WIDTH:       frame_cfg_ff.source_width  <= csr_wr_data[CFG_SIZE_W-1:0];
            REG_SOURCE_HEIGHT:      frame_cfg_ff.source_height <= csr_wr_data[CFG_SIZE_W-1:0];
            REG_DEST_WIDTH:         frame_cfg_ff.dest_width    <= csr_wr_data[CFG_SIZE_W-1:0];
            REG_DEST_HEIGHT:        frame_cfg_ff.dest_height   <= csr_wr_data[CFG_SIZE_W-1:0];
            REG_LUMA_ROW_STRIDE:    luma_stride_ff             <= csr_wr_data[STRIDE_W-1:0];
            REG_CHROMA_ROW_STRIDE:  chroma_stride_ff           <= csr_wr_data[STRIDE_W-1:0];
            REG_CHROMA_INTERLEAVED: interleaved_ff             <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign s2_ready   = !out_valid_ff || rsp_ready;
   assign req_ready  = !s1_valid_ff || s2_ready;
   assign req_accept = req_valid && req_ready;

   r2y_raster u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (req_accept),
      .cfg     (frame_cfg_ff),
      .pos     (pos)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = pos.in_window;
      end else if (s2_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pos_ff   <= pos;
         s1_red_ff   <= req_red;
         s1_green_ff <= req_green;
         s1_blue_ff  <= req_blue;
      end
   end

   r2y_csc u_csc (
      .red      (s1_red_ff),
      .green    (s1_green_ff),
      .blue     (s1_blue_ff),
      .luma     (luma_in),
      .cb_value (cb_in),
      .cr_value (cr_in)
   );

   assign luma_prod      = PROD_W'(s1_pos_ff.row) * PROD_W'(luma_stride_ff);
   assign luma_addr_in   = ADDR_W'(luma_prod + PROD_W'(s1_pos_ff.column));
   assign chroma_prod    = PROD_W'(s1_pos_ff.row[MAX_DIM_BITS-1:1]) *
                           PROD_W'(chroma_stride_ff);
   assign chroma_col_off = interleaved_ff ? {s1_pos_ff.column[MAX_DIM_BITS-1:1], 1'b0}
                                          : MAX_DIM_BITS'(s1_pos_ff.column[MAX_DIM_BITS-1:1]);
   assign chroma_addr_in = ADDR_W'(chroma_prod + PROD_W'(chroma_col_off));

   assign out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         out_luma_ff         <= luma_in;
         out_luma_addr_ff    <= luma_addr_in;
         out_chroma_valid_ff <= s1_pos_ff.chroma;
         out_cb_ff           <= s1_pos_ff.chroma ? cb_in : '0;
         out_cr_ff           <= s1_pos_ff.chroma ? cr_in : '0;
         out_chroma_addr_ff  <= s1_pos_ff.chroma ? chroma_addr_in : '0;
         out_frame_done_ff   <= s1_pos_ff.last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = out_luma_ff;
   assign rsp_luma_addr    = out_luma_addr_ff;
   assign rsp_chroma_valid = out_chroma_valid_ff;
   assign rsp_cb_value     = out_cb_ff;
   assign rsp_cr_value     = out_cr_ff;
   assign rsp_chroma_addr  = out_chroma_addr_ff;
   assign rsp_frame_done   = out_frame_done_ff;

   `R2Y_ASSERT_IMPLY(a_no_chroma_zero, clock, reset, rsp_valid && !rsp_chroma_valid, rsp_cb_value == 8'd0 && rsp_cr_value == 8'd0 && rsp_chroma_addr == '0, "chroma fields not cleared without a chroma sample")
   `R2Y_ASSERT_IMPLY(a_luma_range, clock, reset, rsp_valid, rsp_luma >= 8'd16 && rsp_luma <= 8'd235, "luma outside the BT.601 range")
   `R2Y_ASSERT_NEXT(a_stage_hold, clock, reset, s1_valid_ff && !s2_ready, s1_valid_ff, "input stage lost a pixel during a stall")
   `R2Y_ASSERT_NEXT(a_window_capture, clock, reset, req_accept && pos.in_window, s1_valid_ff, "window pixel not captured")

endmodule

// ----- design/r2y_csc.sv -----
// ----------------------------------------------------------------------------
// BT.601 color space converter
// Integer RGB to Y, Cb and Cr with rounding, offsets and clamping.
// ----------------------------------------------------------------------------
module r2y_csc (
   input  logic [7:0] red,
   input  logic [7:0] green,
   input  logic [7:0] blue,
   output logic [7:0] luma,
   output logic [7:0] cb_value,
   output logic [7:0] cr_value
);

   localparam logic [17:0] Y_COEF_R  = 18'd66;
   localparam logic [17:0] Y_COEF_G  = 18'd129;
   localparam logic [17:0] Y_COEF_B  = 18'd25;
   localparam logic [17:0] CB_COEF_R = 18'd38;
   localparam logic [17:0] CB_COEF_G = 18'd74;
   localparam logic [17:0] CB_COEF_B = 18'd112;
   localparam logic [17:0] CR_COEF_R = 18'd112;
   localparam logic [17:0] CR_COEF_G = 18'd94;
   localparam logic [17:0] CR_COEF_B = 18'd18;
   localparam logic [17:0] ROUND     = 18'd128;
   localparam logic [10:0] Y_OFFSET  = 11'd16;
   localparam logic [10:0] C_OFFSET  = 11'd128;

   function automatic logic [7:0] clamp8(input logic [10:0] v);
      if (v[10]) begin
         clamp8 = 8'd0;
      end else if (v[9:8] != 2'b00) begin
         clamp8 = 8'd255;
      end else begin
         clamp8 = v[7:0];
      end
   endfunction

   logic [17:0] r_ext;
   logic [17:0] g_ext;
   logic [17:0] b_ext;
   logic [17:0] y_sum;
   logic [17:0] cb_sum;
   logic [17:0] cr_sum;
   logic [10:0] y_off;
   logic [10:0] cb_off;
   logic [10:0] cr_off;

   assign r_ext = 18'(red);
   assign g_ext = 18'(green);
   assign b_ext = 18'(blue);

   // Sums are two's complement in 18 bits; bits 17:8 give the floor shift.
   assign y_sum  = r_ext * Y_COEF_R + g_ext * Y_COEF_G + b_ext * Y_COEF_B + ROUND;
   assign cb_sum = b_ext * CB_COEF_B + ROUND - r_ext * CB_COEF_R - g_ext * CB_COEF_G;
   assign cr_sum = r_ext * CR_COEF_R + ROUND - g_ext * CR_COEF_G - b_ext * CR_COEF_B;

   assign y_off  = {y_sum[17], y_sum[17:8]} + Y_OFFSET;
   assign cb_off = {cb_sum[17], cb_sum[17:8]} + C_OFFSET;
   assign cr_off = {cr_sum[17], cr_sum[17:8]} + C_OFFSET;

   assign luma     = clamp8(y_off);
   assign cb_value = clamp8(cb_off);
   assign cr_value = clamp8(cr_off);

endmodule

// ----- design/r2y_raster.sv -----
// ----------------------------------------------------------------------------
// Raster position tracker
// Counts column and row of the source frame and classifies each pixel
// against the copy window.
// ----------------------------------------------------------------------------
module r2y_raster
   import r2y_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  frame_cfg_type cfg,
   output pixel_pos_type pos
);

   localparam int DIM_LIMIT = 1 << MAX_DIM_BITS;
   localparam int CMP_W     = (CFG_SIZE_W > DIM_W) ? CFG_SIZE_W : DIM_W;

   function automatic logic [DIM_W-1:0] eff_size(input logic [CFG_SIZE_W-1:0] v);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(v);
      if (v == '0) begin
         eff_size = DIM_W'(1);
      end else if (wide > CMP_W'(DIM_LIMIT)) begin
         eff_size = DIM_W'(DIM_LIMIT);
      end else begin
         eff_size = DIM_W'(wide);
      end
   endfunction

   logic [MAX_DIM_BITS-1:0] column_ff;
   logic [MAX_DIM_BITS-1:0] column_in;
   logic [MAX_DIM_BITS-1:0] row_ff;
   logic [MAX_DIM_BITS-1:0] row_in;
   logic [DIM_W-1:0]        src_w;
   logic [DIM_W-1:0]        src_h;
   logic [DIM_W-1:0]        dst_w;
   logic [DIM_W-1:0]        dst_h;
   logic [DIM_W-1:0]        win_w;
   logic [DIM_W-1:0]        win_h;
   logic [DIM_W-1:0]        win_w_even;
   logic [DIM_W-1:0]        win_h_even;
   logic [DIM_W-1:0]        col_ext;
   logic [DIM_W-1:0]        row_ext;
   logic [DIM_W-1:0]        col_next;
   logic [DIM_W-1:0]        row_next;

   assign src_w = eff_size(cfg.source_width);
   assign src_h = eff_size(cfg.source_height);
   assign dst_w = eff_size(cfg.dest_width);
   assign dst_h = eff_size(cfg.dest_height);
   assign win_w = (src_w < dst_w) ? src_w : dst_w;
   assign win_h = (src_h < dst_h) ? src_h : dst_h;
   assign win_w_even = {win_w[DIM_W-1:1], 1'b0};
   assign win_h_even = {win_h[DIM_W-1:1], 1'b0};

   assign col_ext  = {1'b0, column_ff};
   assign row_ext  = {1'b0, row_ff};
   assign col_next = col_ext + DIM_W'(1);
   assign row_next = row_ext + DIM_W'(1);

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (advance) begin
         if (col_next >= src_w) begin
            column_in = '0;
            row_in    = (row_next >= src_h) ? '0 : row_next[MAX_DIM_BITS-1:0];
         end else begin
            column_in = col_next[MAX_DIM_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

   assign pos.column    = column_ff;
   assign pos.row       = row_ff;
   assign pos.in_window = (col_ext < win_w) && (row_ext < win_h);
   assign pos.chroma    = !column_ff[0] && !row_ff[0] &&
                          (col_ext < win_w_even) && (row_ext < win_h_even);
   assign pos.last      = (col_ext == win_w - DIM_W'(1)) && (row_ext == win_h - DIM_W'(1));

endmodule

// ----- verif/rgba_to_yuv420_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGBA to YUV 4:2:0 converter testbench
// Streams raster pixels through the converter under a series of frame,
// window and stride settings, predicts each luma/chroma write transaction
// and compares it field by field as it leaves the block.
// ----------------------------------------------------------------------------
module rgba_to_yuv420_converter_tb;
   import r2y_pkg::*;

   localparam int                     CLOCK_PERIOD     = 10;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE        = 3'd7;
   localparam int unsigned            LONG_HOLD_CYCLES = 300;
   localparam int unsigned            RANDOM_RESULTS   = 250;
   localparam int unsigned            SETTLE_CYCLES    = 6;

   typedef struct packed {
      logic [7:0]        luma;
      logic [ADDR_W-1:0] luma_addr;
      logic              chroma_valid;
      logic [7:0]        cb_value;
      logic [7:0]        cr_value;
      logic [ADDR_W-1:0] chroma_addr;
      logic              frame_done;
   } yuv_write_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] src_w;
      logic [CSR_DATA_W-1:0] src_h;
      logic [CSR_DATA_W-1:0] dst_w;
      logic [CSR_DATA_W-1:0] dst_h;
      logic [CSR_DATA_W-1:0] luma_stride;
      logic [CSR_DATA_W-1:0] chroma_stride;
      logic [CSR_DATA_W-1:0] interleave;
   } frame_setup_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       fixed;
      logic [7:0] luma;
      logic [7:0] cb;
      logic [7:0] cr;
   } pixel_stim_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_red     = '0;
   logic [7:0]             req_green   = '0;
   logic [7:0]             req_blue    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   logic [7:0]             rsp_luma;
   logic [ADDR_W-1:0]      rsp_luma_addr;
   logic                   rsp_chroma_valid;
   logic [7:0]             rsp_cb_value;
   logic [7:0]             rsp_cr_value;
   logic [ADDR_W-1:0]      rsp_chroma_addr;
   logic                   rsp_frame_done;

   logic [CFG_SIZE_W-1:0]   pred_src_w;
   logic [CFG_SIZE_W-1:0]   pred_src_h;
   logic [CFG_SIZE_W-1:0]   pred_dst_w;
   logic [CFG_SIZE_W-1:0]   pred_dst_h;
   logic [STRIDE_W-1:0]     pred_luma_stride;
   logic [STRIDE_W-1:0]     pred_chroma_stride;
   logic                    pred_interleave;
   logic [MAX_DIM_BITS-1:0] pred_column;
   logic [MAX_DIM_BITS-1:0] pred_row;

   yuv_write_type pending_writes[$];
   int unsigned   error_count           = 0;
   int unsigned   windowed_pixels       = 0;
   bit            idle_free             = 1'b0;
   bit            receiver_hold_request = 1'b0;

   rgba_to_yuv420_converter u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_luma_addr    (rsp_luma_addr),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_cb_value     (rsp_cb_value),
      .rsp_cr_value     (rsp_cr_value),
      .rsp_chroma_addr  (rsp_chroma_addr),
      .rsp_frame_done   (rsp_frame_done)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic longint unsigned clip_dim(input logic [CFG_SIZE_W-1:0] v);
      if (v == 0) return 1;
      if (v > (1 << MAX_DIM_BITS)) return 1 << MAX_DIM_BITS;
      return v;
   endfunction

   function automatic logic [7:0] clamp_byte(input int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
   endfunction

   function automatic bit convert_pixel(input logic [7:0] red, input logic [7:0] green,
                                        input logic [7:0] blue, output yuv_write_type w);
      longint unsigned sw, sh, ww, wh, col, row, step, addr;
      int              r, g, b;
      bit              hit;
      sw  = clip_dim(pred_src_w);
      sh  = clip_dim(pred_src_h);
      ww  = (clip_dim(pred_dst_w) < sw) ? clip_dim(pred_dst_w) : sw;
      wh  = (clip_dim(pred_dst_h) < sh) ? clip_dim(pred_dst_h) : sh;
      col = pred_column;
      row = pred_row;
      r   = red;
      g   = green;
      b   = blue;
      w   = '0;
      hit = (col < ww) && (row < wh);
      if (hit) begin
         w.luma = clamp_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
         addr = row * pred_luma_stride + col;
         w.luma_addr = addr[ADDR_W-1:0];
         w.chroma_valid = (col % 2 == 0) && (row % 2 == 0) &&
                          (col < ww / 2 * 2) && (row < wh / 2 * 2);
         if (w.chroma_valid) begin
            w.cb_value = clamp_byte(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
            w.cr_value = clamp_byte(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
            step = pred_interleave ? 2 : 1;
            addr = (row / 2) * pred_chroma_stride + (col / 2) * step;
            w.chroma_addr = addr[ADDR_W-1:0];
         end
         w.frame_done = (col == ww - 1) && (row == wh - 1);
      end
      if (col + 1 >= sw) begin
         pred_column = '0;
         pred_row = (row + 1 >= sh) ? '0 : MAX_DIM_BITS'(row + 1);
      end else begin
         pred_column = MAX_DIM_BITS'(col + 1);
      end
      return hit;
   endfunction

   function automatic void store_register(input logic [CSR_INDEX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] data);
      case (index)
         REG_SOURCE_WIDTH:       pred_src_w = data[CFG_SIZE_W-1:0];
         REG_SOURCE_HEIGHT:      pred_src_h = data[CFG_SIZE_W-1:0];
         REG_DEST_WIDTH:         pred_dst_w = data[CFG_SIZE_W-1:0];
         REG_DEST_HEIGHT:        pred_dst_h = data[CFG_SIZE_W-1:0];
         REG_LUMA_ROW_STRIDE:    pred_luma_stride = data[STRIDE_W-1:0];
         REG_CHROMA_ROW_STRIDE:  pred_chroma_stride = data[STRIDE_W-1:0];
         REG_CHROMA_INTERLEAVED: pred_interleave = data[0];
         default: ;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] source_dim();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(13, 40));
         default: return CSR_DATA_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] dest_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return CSR_DATA_W'($urandom_range(4097, 8191));
         2:       return CSR_DATA_W'($urandom);
         default: return CSR_DATA_W'($urandom_range(1, 14));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] row_stride();
      case ($urandom_range(0, 3))
         0:       return CSR_DATA_W'($urandom);
         1:       return '0;
         default: return CSR_DATA_W'($urandom_range(1, 48));
      endcase
   endfunction

   function automatic frame_setup_type random_setup();
      frame_setup_type s;
      s.src_w         = source_dim();
      s.src_h         = source_dim();
      s.dst_w         = dest_dim();
      s.dst_h         = dest_dim();
      s.luma_stride   = row_stride();
      s.chroma_stride = row_stride();
      s.interleave    = CSR_DATA_W'($urandom);
      return s;
   endfunction

   function automatic logic [7:0] pick_channel();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic pixel_stim_type random_pixel();
      pixel_stim_type p;
      p       = '0;
      p.red   = pick_channel();
      p.green = pick_channel();
      p.blue  = pick_channel();
      return p;
   endfunction

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endfunction

   task automatic send_pixel(input pixel_stim_type p);
      yuv_write_type w;
      if (!idle_free && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= p.red;
      req_green <= p.green;
      req_blue  <= p.blue;
      do @(posedge clock); while (!req_ready);
      if (convert_pixel(p.red, p.green, p.blue, w)) begin
         if (p.fixed) begin
            w.luma     = p.luma;
            w.cb_value = p.cb;
            w.cr_value = p.cr;
         end
         pending_writes = {pending_writes, w};
         windowed_pixels++;
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      store_register(index, data);
   endtask

   task automatic apply_setup(input frame_setup_type s);
      write_register(REG_SOURCE_WIDTH, s.src_w);
      write_register(REG_SOURCE_HEIGHT, s.src_h);
      write_register(REG_DEST_WIDTH, s.dst_w);
      write_register(REG_DEST_HEIGHT, s.dst_h);
      write_register(REG_LUMA_ROW_STRIDE, s.luma_stride);
      write_register(REG_CHROMA_ROW_STRIDE, s.chroma_stride);
      write_register(REG_CHROMA_INTERLEAVED, s.interleave);
      write_register(REG_SPARE, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random_phase(input int unsigned min_results, input int unsigned max_items);
      int unsigned goal;
      int unsigned sent;
      goal = windowed_pixels + min_results;
      sent = 0;
      while (windowed_pixels < goal && sent < max_items) begin
         send_pixel(random_pixel());
         sent++;
      end
   endtask

   initial begin : stimulus
      pixel_stim_type  directed[18];
      frame_setup_type fixed_setups[5];
      int unsigned     fixed_items[5];
      int unsigned     random_start;

      // Reset geometry puts these pixels on row 0, columns 0 upward.
      directed = '{
         '{8'd0,   8'd0,   8'd0,   1'b1, 8'd16,  8'd128, 8'd128},
         '{8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd0,   8'd0},
         '{8'd255, 8'd255, 8'd255, 1'b1, 8'd235, 8'd128, 8'd128},
         '{8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd0,   8'd0},
         '{8'd255, 8'd0,   8'd0,   1'b1, 8'd82,  8'd90,  8'd240},
         '{8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd0,   8'd0},
         '{8'd0,   8'd255, 8'd0,   1'b1, 8'd144, 8'd54,  8'd34},
         '{8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd0,   8'd0},
         '{8'd0,   8'd0,   8'd255, 1'b1, 8'd41,  8'd240, 8'd110},
         '{8'd255, 8'd0,   8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd0,   8'd255, 8'd255, 1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd255, 8'd255, 8'd0,   1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd128, 8'd128, 8'd128, 1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd127, 8'd127, 8'd127, 1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd1,   8'd2,   8'd4,   1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd170, 8'd85,  8'd170, 1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd85,  8'd170, 8'd85,  1'b0, 8'd0,   8'd0,   8'd0},
         '{8'd254, 8'd253, 8'd251, 1'b0, 8'd0,   8'd0,   8'd0}
      };
      // Small frame, zero sizes, zero strides, widest row, tallest frame.
      fixed_setups = '{
         '{15'd4,      15'd3,    15'd4,    15'd3,    15'd8,     15'd8,     15'd0},
         '{15'd0,      15'd0,    15'd0,    15'd0,    15'd0,     15'd0,     15'd0},
         '{15'd5,      15'd5,    15'd3,    15'd4,    15'd0,     15'd0,     15'd1},
         '{15'h7FFF,   15'd1,    15'd4096, 15'd8191, 15'd32767, 15'd32767, 15'd1},
         '{15'd2,      15'd4097, 15'd8191, 15'd4096, 15'd32767, 15'd32767, 15'd0}
      };
      fixed_items = '{30, 6, 40, 120, 120};

      pred_src_w         = RESET_WIDTH;
      pred_src_h         = RESET_HEIGHT;
      pred_dst_w         = RESET_WIDTH;
      pred_dst_h         = RESET_HEIGHT;
      pred_luma_stride   = RESET_STRIDE;
      pred_chroma_stride = RESET_STRIDE;
      pred_interleave    = 1'b0;
      pred_column        = '0;
      pred_row           = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_pixel(directed[i]);

      foreach (fixed_setups[i]) begin
         drain_pipeline();
         apply_setup(fixed_setups[i]);
         if (i == 0) receiver_hold_request = 1'b1;
         repeat (fixed_items[i]) send_pixel(random_pixel());
      end

      random_start = windowed_pixels;
      while (windowed_pixels - random_start < RANDOM_RESULTS) begin
         drain_pipeline();
         apply_setup(random_setup());
         run_random_phase($urandom_range(20, 80), 400);
      end

      drain_pipeline();
      apply_setup(random_setup());
      idle_free = 1'b1;
      run_random_phase(100, 300);
      drain_pipeline();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin : rsp_side
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (receiver_hold_request) begin
            receiver_hold_request = 1'b0;
            hold = LONG_HOLD_CYCLES;
         end else if (hold == 0 && !idle_free && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 18);
         end
         if (hold != 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : write_check
      yuv_write_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_writes.size() == 0) begin
            $error("Unexpected transaction: luma %0d at address %0d", rsp_luma, rsp_luma_addr);
            error_count++;
         end else begin
            want = pending_writes.pop_front();
            check_field("luma", want.luma, rsp_luma);
            check_field("luma_addr", want.luma_addr, rsp_luma_addr);
            check_field("chroma_valid", want.chroma_valid, rsp_chroma_valid);
            check_field("cb_value", want.cb_value, rsp_cb_value);
            check_field("cr_value", want.cr_value, rsp_cr_value);
            check_field("chroma_addr", want.chroma_addr, rsp_chroma_addr);
            check_field("frame_done", want.frame_done, rsp_frame_done);
         end
      end
   end

   initial begin : watchdog
      #30_000_000;
      $error("Simulation timed out with %0d transactions outstanding.", pending_writes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/r2y_pkg.sv
design/r2y_csc.sv
design/r2y_raster.sv
design/rgba_to_yuv420_converter.sv
verif/rgba_to_yuv420_converter_tb.sv
